@@ hw/rtl/ipv6tc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tc_pkg
// Shared types, constants and helpers for the IPv6 address to text block.
// ----------------------------------------------------------------------------
package ipv6tc_pkg;

  localparam int unsigned GroupW   = 16;
  localparam int unsigned NumGroup = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CharW    = 7;

  localparam logic [CharW-1:0] CHAR_COLON = 7'h3a;
  localparam logic [CharW-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CharW-1:0] CHAR_ALPHA = 7'h57;  // 'a' minus ten

  // longest zero run found by the scan; len of zero means no run
  typedef struct packed {
    logic [IdxW-1:0] start;
    logic [LenW-1:0] len;
  } run_t;

  // one character leaving the emitter
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_t;

  // group idx of the address, group 0 in the top bits of the high half
  function automatic logic [GroupW-1:0] group_sel(input logic [127:0] addr,
                                                  input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] pos;
    pos = 3'd7 - idx;
    return addr[{pos, 4'd0} +: GroupW];
  endfunction

  // lowercase hex digit
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + {3'd0, nib};
    end else begin
      return CHAR_ALPHA + {3'd0, nib};
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ipv6tc_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tc_scan
// Walks the eight groups one per cycle and keeps the first longest zero run.
// ----------------------------------------------------------------------------
module ipv6tc_scan
  import ipv6tc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [GroupW-1:0] grp_i,
  output logic      [IdxW-1:0]   idx_o,
  output logic                   done_o,
  output run_t                   run_o
);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] cur_start_q, cur_start_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;
  run_t            best_q, best_d;
  logic [IdxW-1:0] st_eff;
  logic [LenW-1:0] len_inc;

  // one compare step per group
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    best_d      = best_q;
    st_eff      = (cur_len_q == '0) ? idx_q : cur_start_q;
    len_inc     = cur_len_q + 4'd1;
    if (start_i) begin
      busy_d    = 1'b1;
      idx_d     = '0;
      cur_len_d = '0;
      best_d    = '0;
    end else if (busy_q) begin
      if (grp_i == '0) begin
        cur_start_d = st_eff;
        cur_len_d   = len_inc;
        if (len_inc > best_q.len) begin
          best_d.start = st_eff;
          best_d.len   = len_inc;
        end
      end else begin
        cur_len_d = '0;
      end
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      cur_start_q <= '0;
      cur_len_q   <= '0;
      best_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      cur_start_q <= cur_start_d;
      cur_len_q   <= cur_len_d;
      best_q      <= best_d;
    end
  end

  assign idx_o  = idx_q;
  assign done_o = busy_q && (idx_q == 3'd7);
  assign run_o  = best_q;

endmodule
`default_nettype wire

@@ hw/rtl/ipv6tc_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tc_emit
// Character sequencer: shifts each group out a nibble at a time, drops
// leading zeros, inserts colons and writes the zero run as a double colon.
// ----------------------------------------------------------------------------
module ipv6tc_emit
  import ipv6tc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire run_t              run_i,
  input  wire logic [GroupW-1:0] grp_i,
  input  wire logic              adv_i,
  output logic      [IdxW-1:0]   idx_o,
  output logic                   valid_o,
  output char_t                  char_o,
  output logic                   done_o
);

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_LOAD  = 3'd1;
  localparam logic [2:0] E_DIGIT = 3'd2;
  localparam logic [2:0] E_COLON = 3'd3;
  localparam logic [2:0] E_RUN0  = 3'd4;
  localparam logic [2:0] E_RUN1  = 3'd5;

  logic [2:0]        st_q, st_d;
  logic [IdxW-1:0]   gi_q, gi_d;
  logic [GroupW-1:0] sh_q, sh_d;
  logic [1:0]        nib_q, nib_d;
  logic              started_q, started_d;
  logic              has_run;
  logic [LenW-1:0]   run_end;
  logic [3:0]        dig;
  logic              show;

  assign has_run = (run_i.len != '0);
  assign run_end = {1'b0, run_i.start} + run_i.len;
  assign dig     = sh_q[GroupW-1 -: 4];
  assign show    = (dig != 4'd0) || started_q || (nib_q == 2'd0);

  // sequencer
  always_comb begin
    st_d      = st_q;
    gi_d      = gi_q;
    sh_d      = sh_q;
    nib_d     = nib_q;
    started_d = started_q;
    valid_o   = 1'b0;
    char_o    = '{ch: CHAR_COLON, last: 1'b0};
    done_o    = 1'b0;
    case (st_q)
      E_IDLE: begin
        if (start_i) begin
          gi_d = '0;
          st_d = E_LOAD;
        end
      end
      E_LOAD: begin
        if (has_run && (gi_q == run_i.start)) begin
          st_d = (gi_q == '0) ? E_RUN0 : E_RUN1;
        end else begin
          sh_d      = grp_i;
          nib_d     = 2'd3;
          started_d = 1'b0;
          st_d      = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (!show) begin
          sh_d  = {sh_q[GroupW-5:0], 4'd0};
          nib_d = nib_q - 2'd1;
        end else begin
          valid_o     = 1'b1;
          char_o.ch   = hex_char(dig);
          char_o.last = (nib_q == 2'd0) && (gi_q == 3'd7);
          if (adv_i) begin
            sh_d      = {sh_q[GroupW-5:0], 4'd0};
            nib_d     = nib_q - 2'd1;
            started_d = 1'b1;
            if (nib_q == 2'd0) begin
              if (gi_q == 3'd7) begin
                done_o = 1'b1;
                st_d   = E_IDLE;
              end else begin
                st_d = E_COLON;
              end
            end
          end
        end
      end
      E_COLON: begin
        valid_o = 1'b1;
        if (adv_i) begin
          gi_d = gi_q + 3'd1;
          st_d = E_LOAD;
        end
      end
      E_RUN0: begin
        valid_o = 1'b1;
        if (adv_i) begin
          st_d = E_RUN1;
        end
      end
      E_RUN1: begin
        valid_o     = 1'b1;
        char_o.last = (run_end == 4'd8);
        if (adv_i) begin
          if (run_end == 4'd8) begin
            done_o = 1'b1;
            st_d   = E_IDLE;
          end else begin
            gi_d = run_end[IdxW-1:0];
            st_d = E_LOAD;
          end
        end
      end
      default: begin
        st_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= E_IDLE;
      gi_q      <= '0;
      nib_q     <= '0;
      started_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      gi_q      <= gi_d;
      nib_q     <= nib_d;
      started_q <= started_d;
    end
  end

  // group shifter
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign idx_o = gi_q;

endmodule
`default_nettype wire

@@ hw/rtl/ipv6_address_to_compressed_text.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_address_to_compressed_text
// IPv6 address to compressed lowercase text, one ASCII character per beat.
//
//   channel  dir  width  contents
//   s_axis   in   128    address_high [63:0], address_low [127:64]
//   m_axis   out  8      out_char [6:0], zero [7]; tlast = last_char
//
// One address at a time: accept, a zero-run scan over the eight groups,
// then per written group a load step, a digit step for each nibble and
// a colon step between groups, plus a load step and the colon steps for
// the double colon. The character sequencer sets the pace.
// Asynchronous active-low reset returns to idle with no output pending.
// Output stalls hold the sequencer; s_axis_tready is high only when idle.
// ----------------------------------------------------------------------------
module ipv6_address_to_compressed_text
  import ipv6tc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // address_high [63:0], address_low [127:64]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_char [6:0], zero pad [7]
  output logic              m_axis_tlast    // last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [127:0]      addr_q;
  logic              in_acc;
  logic [IdxW-1:0]   scan_idx, emit_idx, grp_idx;
  logic [GroupW-1:0] grp;
  logic              scan_done, emit_done, emit_valid, adv;
  run_t              run;
  char_t             emit_char;
  logic              out_valid_q;
  char_t             out_q;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // address register, group {high, low} so group 0 sits on top
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    end
  end

  // shared group select
  assign grp_idx = (st_q == ST_SCAN) ? scan_idx : emit_idx;
  assign grp     = group_sel(addr_q, grp_idx);

  ipv6tc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .grp_i   (grp),
    .idx_o   (scan_idx),
    .done_o  (scan_done),
    .run_o   (run)
  );

  assign adv = !out_valid_q || m_axis_tready;

  ipv6tc_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_done),
    .run_i   (run),
    .grp_i   (grp),
    .adv_i   (adv),
    .idx_o   (emit_idx),
    .valid_o (emit_valid),
    .char_o  (emit_char),
    .done_o  (emit_done)
  );

  // top sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_acc)    st_d = ST_SCAN;
      ST_SCAN: if (scan_done) st_d = ST_EMIT;
      ST_EMIT: if (emit_done) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (adv) begin
        out_valid_q <= emit_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_valid) begin
      out_q <= emit_char;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.ch};
  assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire

@@ test/ipv6_text_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_compare
// Watches both stream channels of the IPv6 address to text block, predicts
// the compressed text of every accepted address and compares it, character
// by character, with what leaves the master side.
// ----------------------------------------------------------------------------
module ipv6_text_compare
  import ipv6tc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [127:0] s_axis_tdata_i,   // address_high [63:0], address_low [127:64]
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [7:0]   m_axis_tdata_i,   // out_char [6:0], zero pad [7]
  input  wire logic         m_axis_tlast_i,   // last_char
  output int                errors_o,
  output int                pending_o
);

  localparam logic [CharW-1:0] AsciiZero   = 7'h30;
  localparam logic [CharW-1:0] AsciiLowerA = 7'h61;
  localparam int unsigned      ReportMax   = 10;

  // characters still owed by the block, oldest first
  char_t expected_text[$];

  // text form of one address, longest zero run (first on a tie) as double colon
  function automatic void predict_text(input logic [63:0] addr_hi,
                                       input logic [63:0] addr_lo);
    logic [GroupW-1:0] grp [NumGroup];
    char_t             text [$];
    char_t             c;
    logic [3:0]        nib;
    int                best_start;
    int                best_len;
    int                run_start;
    int                run_len;
    int                idx;
    int                s;
    bit                started;

    for (idx = 0; idx < 4; idx++) begin
      grp[idx]     = addr_hi[(3 - idx) * 16 +: 16];
      grp[idx + 4] = addr_lo[(3 - idx) * 16 +: 16];
    end

    // find the longest run of zero groups
    best_start = -1;
    best_len   = 0;
    run_start  = -1;
    run_len    = 0;
    for (idx = 0; idx < NumGroup; idx++) begin
      if (grp[idx] == '0) begin
        if (run_start < 0) begin
          run_start = idx;
        end
        run_len++;
        if (run_len > best_len) begin
          best_start = run_start;
          best_len   = run_len;
        end
      end else begin
        run_start = -1;
        run_len   = 0;
      end
    end

    // write groups and separators
    c.last = 1'b0;
    idx    = 0;
    while (idx < NumGroup) begin
      if (idx == best_start) begin
        c.ch = CHAR_COLON;
        if (idx == 0) begin
          text.push_back(c);
        end
        text.push_back(c);
        idx += best_len;
      end else begin
        started = 1'b0;
        for (s = 12; s >= 0; s -= 4) begin
          nib = grp[idx][s +: 4];
          if (nib != 4'd0 || started || s == 0) begin
            c.ch    = (nib < 4'd10) ? AsciiZero + CharW'(nib)
                                    : AsciiLowerA + CharW'(nib) - CharW'(10);
            started = 1'b1;
            text.push_back(c);
          end
        end
        if (idx < NumGroup - 1) begin
          c.ch = CHAR_COLON;
          text.push_back(c);
        end
        idx++;
      end
    end

    text[text.size() - 1].last = 1'b1;
    foreach (text[k]) begin
      expected_text.push_back(text[k]);
    end
  endfunction

  // predict on address transactions, compare on character transactions
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_text(s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_text.size() == 0) begin
          if (errors_o < ReportMax) begin
            $display("%0t: character tdata %h last %b with no text pending",
                     $time, m_axis_tdata_i, m_axis_tlast_i);
          end
          errors_o++;
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata_i != {1'b0, want.ch} || m_axis_tlast_i != want.last) begin
            if (errors_o < ReportMax) begin
              $display("%0t: text mismatch: expected tdata %h last %b, got tdata %h last %b",
                       $time, {1'b0, want.ch}, want.last, m_axis_tdata_i,
                       m_axis_tlast_i);
            end
            errors_o++;
          end
        end
      end
      pending_o = expected_text.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives IPv6 addresses into the address to text block: a directed set of
// zero-run shapes, then random addresses built mostly from zero and short
// groups, with random gaps on the address side and random output stalls.
// The compare module predicts and checks the text; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ipv6tc_pkg::*;

  localparam int unsigned RandomItems = 310;
  localparam int unsigned CalmItems   = 40;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 64;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;
  int           errors;
  int           pending;
  int           quiet_cycles;
  bit           gaps_on;
  logic [63:0]  rand_hi;
  logic [63:0]  rand_lo;

  always #1 clk = ~clk;

  ipv6_address_to_compressed_text dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ipv6_text_compare u_compare (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // one address transaction, entered and left at a falling edge
  task automatic send_address(input logic [63:0] addr_hi, input logic [63:0] addr_lo);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr_lo, addr_hi};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the address side until every owed character has left
  task automatic wait_text_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // random group, biased toward zero and short hex strings
  function automatic logic [15:0] random_group();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return 16'h0000;
      4:          return 16'($urandom_range(1, 16'h000f));
      5:          return 16'($urandom_range(16'h0010, 16'h00ff));
      6:          return 16'($urandom_range(16'h0100, 16'h0fff));
      default:    return 16'($urandom);
    endcase
  endfunction

  // output side stalls in random bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus and verdict
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_n         = 1'b0;
    gaps_on       = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all zero, all ones, no zero group with every digit count
    send_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
    send_address(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_address(64'h0001_0012_0123_1234, 64'habcd_0bcd_00cd_000d);
    send_address(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    // run at the start, run at the end
    send_address(64'h0000_0000_0001_0002, 64'h0003_0004_0005_0006);
    send_address(64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000);
    // equal runs pick the first, a longer later run wins
    send_address(64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004);
    send_address(64'h0001_0000_0002_0000, 64'h0000_0003_0004_0005);
    // single zero group at the start, the end and the middle
    send_address(64'h0000_0001_0002_0003, 64'h0004_0005_0006_0007);
    send_address(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000);
    send_address(64'h0001_0002_0003_0000, 64'h0005_0006_0007_0008);
    // alternating single zeros, runs of seven on either side
    send_address(64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001);
    send_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_address(64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000);
    // equal runs at both ends
    send_address(64'h0000_ffff_ffff_ffff, 64'hffff_ffff_ffff_0000);
    send_address(64'h2001_0db8_0000_0000, 64'h0000_ff00_0042_8329);
    send_address(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
    send_address(64'hfe80_0000_0000_0000, 64'h0202_b3ff_fe1e_8329);
    send_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);

    // random addresses, mostly shaped groups, some raw bits
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        wait_text_drained();
      end
      if (n == RandomItems - CalmItems) begin
        gaps_on = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
        rand_hi = {$urandom, $urandom};
        rand_lo = {$urandom, $urandom};
      end else begin
        rand_hi = {random_group(), random_group(), random_group(), random_group()};
        rand_lo = {random_group(), random_group(), random_group(), random_group()};
      end
      send_address(rand_hi, rand_lo);
    end

    wait_text_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ipv6tc_pkg.sv
hw/rtl/ipv6tc_scan.sv
hw/rtl/ipv6tc_emit.sv
hw/rtl/ipv6_address_to_compressed_text.sv
test/ipv6_text_compare.sv
test/testbench.sv
